// File: rtl/mhd_pkg.sv
// Shared types and constants for the magic header frame deframer.
package mhd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_W = 16;

   // Configuration register indexes
   localparam logic REG_MAGIC   = 1'b0;
   localparam logic REG_MAX_LEN = 1'b1;

   // Input item modes
   localparam logic MODE_BYTE    = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   localparam logic [BYTE_W-1:0] MAGIC_RESET   = 8'h00;
   localparam logic [WORD_W-1:0] MAX_LEN_RESET = 16'd1024;

   typedef enum logic [8:0] {
      PH_HUNT    = 9'b000000001,
      PH_FLAGS   = 9'b000000010,
      PH_LEN_LO  = 9'b000000100,
      PH_LEN_HI  = 9'b000001000,
      PH_CRC_LO  = 9'b000010000,
      PH_CRC_HI  = 9'b000100000,
      PH_TID_LO  = 9'b001000000,
      PH_TID_HI  = 9'b010000000,
      PH_PAYLOAD = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic [WORD_W-1:0] byte_index;
      logic              last_byte;
      logic [BYTE_W-1:0] frame_flags;
      logic [WORD_W-1:0] frame_length;
      logic [WORD_W-1:0] frame_checksum;
      logic [WORD_W-1:0] transaction_id;
   } result_type;

endpackage

// File: rtl/mhd_parser.sv
// Header parser state machine: header capture, payload indexing, frame hold.
module mhd_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      mode,
   input  logic [mhd_pkg::BYTE_W-1:0] data_byte,
   input  logic [mhd_pkg::BYTE_W-1:0] magic_value,
   input  logic [mhd_pkg::WORD_W-1:0] max_payload_length,
   output logic                      res_valid,
   output mhd_pkg::result_type       res
);

   mhd_pkg::phase_type        phase_ff, phase_in;
   logic [mhd_pkg::BYTE_W-1:0] flags_ff, flags_in;
   logic [mhd_pkg::WORD_W-1:0] length_ff, length_in;
   logic [mhd_pkg::WORD_W-1:0] checksum_ff, checksum_in;
   logic [mhd_pkg::WORD_W-1:0] id_ff, id_in;
   logic [mhd_pkg::WORD_W-1:0] taken_ff, taken_in;
   logic                       pending_ff, pending_in;

   logic [mhd_pkg::WORD_W-1:0] len_cat;
   logic [mhd_pkg::WORD_W:0]   idx_next;
   logic                       is_last;

   assign len_cat  = {data_byte, length_ff[mhd_pkg::BYTE_W-1:0]};
   assign idx_next = {1'b0, taken_ff} + {{mhd_pkg::WORD_W{1'b0}}, 1'b1};
   assign is_last  = idx_next >= {1'b0, length_ff};

   always_comb begin
      phase_in    = phase_ff;
      flags_in    = flags_ff;
      length_in   = length_ff;
      checksum_in = checksum_ff;
      id_in       = id_ff;
      taken_in    = taken_ff;
      pending_in  = pending_ff;
      res_valid   = 1'b0;
      res         = '0;
      if (step) begin
         if (mode == mhd_pkg::MODE_RELEASE) begin
            if (pending_ff) begin
               pending_in = 1'b0;
               phase_in   = mhd_pkg::PH_HUNT;
            end
         end else if (!pending_ff) begin
            unique case (phase_ff)
               mhd_pkg::PH_FLAGS: begin
                  flags_in = data_byte;
                  phase_in = mhd_pkg::PH_LEN_LO;
               end
               mhd_pkg::PH_LEN_LO: begin
                  length_in = {{mhd_pkg::BYTE_W{1'b0}}, data_byte};
                  phase_in  = mhd_pkg::PH_LEN_HI;
               end
               mhd_pkg::PH_LEN_HI: begin
                  length_in = len_cat;
                  if (len_cat == '0 || len_cat > max_payload_length) begin
                     phase_in = mhd_pkg::PH_HUNT;
                  end else begin
                     phase_in = mhd_pkg::PH_CRC_LO;
                  end
               end
               mhd_pkg::PH_CRC_LO: begin
                  checksum_in = {{mhd_pkg::BYTE_W{1'b0}}, data_byte};
                  phase_in    = mhd_pkg::PH_CRC_HI;
               end
               mhd_pkg::PH_CRC_HI: begin
                  checksum_in = {data_byte, checksum_ff[mhd_pkg::BYTE_W-1:0]};
                  phase_in    = mhd_pkg::PH_TID_LO;
               end
               mhd_pkg::PH_TID_LO: begin
                  id_in    = {{mhd_pkg::BYTE_W{1'b0}}, data_byte};
                  phase_in = mhd_pkg::PH_TID_HI;
               end
               mhd_pkg::PH_TID_HI: begin
                  id_in    = {data_byte, id_ff[mhd_pkg::BYTE_W-1:0]};
                  taken_in = '0;
                  phase_in = mhd_pkg::PH_PAYLOAD;
               end
               mhd_pkg::PH_PAYLOAD: begin
                  res_valid        = 1'b1;
                  res.payload_byte = data_byte;
                  res.byte_index   = taken_ff;
                  res.last_byte    = is_last;
                  if (is_last) begin
                     res.frame_flags    = flags_ff;
                     res.frame_length   = length_ff;
                     res.frame_checksum = checksum_ff;
                     res.transaction_id = id_ff;
                     pending_in         = 1'b1;
                  end else begin
                     taken_in = idx_next[mhd_pkg::WORD_W-1:0];
                  end
               end
               default: begin
                  // hunting, or any illegal code: test for the magic byte
                  if (data_byte == magic_value) begin
                     phase_in = mhd_pkg::PH_FLAGS;
                  end else begin
                     phase_in = mhd_pkg::PH_HUNT;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= mhd_pkg::PH_HUNT;
         flags_ff    <= '0;
         length_ff   <= '0;
         checksum_ff <= '0;
         id_ff       <= '0;
         taken_ff    <= '0;
         pending_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         flags_ff    <= flags_in;
         length_ff   <= length_in;
         checksum_ff <= checksum_in;
         id_ff       <= id_in;
         taken_ff    <= taken_in;
         pending_ff  <= pending_in;
      end
   end

   // a held frame only ever sits in the payload phase
   a_pending_in_payload: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> phase_ff == mhd_pkg::PH_PAYLOAD)
      else $error("frame pending outside payload phase");

   // payload index stays inside the announced length
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == mhd_pkg::PH_PAYLOAD |-> taken_ff < length_ff)
      else $error("payload index beyond frame length");

   // completing a frame holds the parser until release
   a_last_sets_pending: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.last_byte |=> pending_ff)
      else $error("last byte did not hold the frame");

endmodule

// File: rtl/mhd_out_reg.sv
// Result register with valid/stall handshake toward the consumer.
module mhd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mhd_pkg::result_type load_data,
   input  logic                rsp_stall,
   output logic                out_free,
   output logic                rsp_valid,
   output mhd_pkg::result_type rsp_data
);

   logic                valid_ff, valid_in;
   mhd_pkg::result_type data_ff;

   assign out_free  = !valid_ff || !rsp_stall;
   assign valid_in  = out_free ? load : valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && out_free) begin
         data_ff <= load_data;
      end
   end

endmodule

// File: rtl/magic_header_frame_deframer.sv
// Top level of the magic header frame deframer: input register, config, parser, result register.
//
// Bytes arrive on the req_ channel, one per transfer, and the block sustains one transfer
// per clock while rsp_stall does not hold the output register. An accepted item lands in an
// input register; once the output register is free the parser updates its header state
// and, for a payload byte, writes one result into the output register, so a result passes
// through the input and output registers before it is presented on rsp_. Only payload
// bytes produce results; header bytes, hunted bytes, bytes dropped while a completed frame
// is held, and release items produce none. The final payload byte carries the flags,
// length, checksum (passed through unchecked) and transaction id; earlier bytes show zero
// there. After that the parser drops bytes until a release item (req_mode = 1) sends it
// back to hunting for the magic byte. req_stall follows rsp_stall only when the input
// register is full and the output register holds a result that is not being taken.
// Registers (csr_index 0: magic value, 1: maximum payload length, reset 1024) are to be
// written by the user only while no transfer is in flight; the block does not enforce it.
module magic_header_frame_deframer (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_mode,
   input  logic [mhd_pkg::BYTE_W-1:0] req_data_byte,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [mhd_pkg::BYTE_W-1:0] rsp_payload_byte,
   output logic [mhd_pkg::WORD_W-1:0] rsp_byte_index,
   output logic                       rsp_last_byte,
   output logic [mhd_pkg::BYTE_W-1:0] rsp_frame_flags,
   output logic [mhd_pkg::WORD_W-1:0] rsp_frame_length,
   output logic [mhd_pkg::WORD_W-1:0] rsp_frame_checksum,
   output logic [mhd_pkg::WORD_W-1:0] rsp_transaction_id,
   // configuration writes
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [mhd_pkg::WORD_W-1:0] csr_write_data
);

   // configuration registers
   logic [mhd_pkg::BYTE_W-1:0] magic_ff;
   logic [mhd_pkg::WORD_W-1:0] max_len_ff;

   // input register
   logic                       in_valid_ff, in_valid_in;
   logic                       in_mode_ff;
   logic [mhd_pkg::BYTE_W-1:0] in_byte_ff;

   logic                req_accept;
   logic                step;
   logic                out_free;
   logic                res_valid;
   mhd_pkg::result_type res;
   mhd_pkg::result_type rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= mhd_pkg::MAGIC_RESET;
         max_len_ff <= mhd_pkg::MAX_LEN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mhd_pkg::REG_MAGIC:   magic_ff   <= csr_write_data[mhd_pkg::BYTE_W-1:0];
            mhd_pkg::REG_MAX_LEN: max_len_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // the parser consumes the held item whenever the result register can take a result
   assign step       = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_mode_ff <= req_mode;
         in_byte_ff <= req_data_byte;
      end
   end

   mhd_parser u_parser (
      .clock              (clock),
      .reset              (reset),
      .step               (step),
      .mode               (in_mode_ff),
      .data_byte          (in_byte_ff),
      .magic_value        (magic_ff),
      .max_payload_length (max_len_ff),
      .res_valid          (res_valid),
      .res                (res)
   );

   mhd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step && res_valid),
      .load_data (res),
      .rsp_stall (rsp_stall),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_byte_index     = rsp_data.byte_index;
   assign rsp_last_byte      = rsp_data.last_byte;
   assign rsp_frame_flags    = rsp_data.frame_flags;
   assign rsp_frame_length   = rsp_data.frame_length;
   assign rsp_frame_checksum = rsp_data.frame_checksum;
   assign rsp_transaction_id = rsp_data.transaction_id;

endmodule
